// ----- hw/rtl/fbpa_pkg.sv -----
package fbpa_pkg;

    // Defaults for the top-level parameters.
    localparam int MaxPagesDef  = 8;
    localparam int MaxBlocksDef = 256;

    // Fixed field widths of the request and response words.
    localparam int PageFieldW = 3;
    localparam int SlotFieldW = 8;
    localparam int OffsetW    = 24;
    localparam int BlockSizeW = 16;
    localparam int BppW       = 9;
    localparam int CfgDataW   = 16;
    localparam int CfgIndexW  = 1;

    // Register reset values.
    localparam logic [BlockSizeW-1:0] BlockSizeRst = 16'd8;
    localparam logic [BppW-1:0]       BppRst       = 9'd256;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] REG_BLOCK_SIZE      = 1'b0;
    localparam logic [CfgIndexW-1:0] REG_BLOCKS_PER_PAGE = 1'b1;

    // Request operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_FREED   = 2'd1,
        ST_NOPAGE  = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    typedef struct packed {
        t_status               status;
        logic [PageFieldW-1:0] out_page;
        logic [SlotFieldW-1:0] out_slot;
        logic [OffsetW-1:0]    byte_offset;
    } t_result;

endpackage

// ----- hw/rtl/fbpa_req_if.sv -----
interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [PageFieldW-1:0] free_page;
    logic [SlotFieldW-1:0] free_slot;

    modport source (output valid, output operation, output free_page, output free_slot,
                    input ready);
    modport sink   (input valid, input operation, input free_page, input free_slot,
                    output ready);
endinterface

// ----- hw/rtl/fbpa_rsp_if.sv -----
interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [PageFieldW-1:0] out_page;
    logic [SlotFieldW-1:0] out_slot;
    logic [OffsetW-1:0]    byte_offset;

    modport source (output valid, output status, output out_page, output out_slot,
                    output byte_offset, input ready);
    modport sink   (input valid, input status, input out_page, input out_slot,
                    input byte_offset, output ready);
endinterface

// ----- hw/rtl/fbpa_result_q.sv -----
module fbpa_result_q
    import fbpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_pop
);

    // Two-entry queue so a result can be produced while the previous one waits.
    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/fixed_block_pool_allocator.sv -----
// Fixed-size block pool allocator.
// Requests arrive on i_req as words with an operation bit: allocate, or free
// the block named by free_page and free_slot. Every request produces exactly
// one response word on o_rsp with a status, and for a successful allocation
// the page, the slot and the byte offset (slot times block_size) of the block.
// Both channels use a valid/ready handshake; a word moves when both are high.
// Block size and blocks per page are written through the i_cfg_* port; the user
// must write them only while no request is in flight: the block does not enforce it.
// A free, a bump allocation, a new page and an out-of-pages reply update
// the state when the request is accepted. An allocation that pops a free
// list also passes through S_POP, because the next free-list link comes from
// the synchronous link memory through r_link_rd; the new list head is written in S_POP.
// The response is registered in the output queue before it appears on o_rsp.
// Results go into a two-word output queue, so a stalled receiver does not
// stop the block until the queue holds two words; then i_req.ready drops.
// Reset opens page 0, empties all free lists, clears the bump counts and sets
// block_size to 8 and blocks_per_page to 256. The link memory is not cleared:
// an entry is always written before a pop reads it.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_PAGES  = MaxPagesDef,
    parameter int MAX_BLOCKS = MaxBlocksDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fbpa_req_if.sink             i_req,
    fbpa_rsp_if.source           o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_wdata
);

    localparam int PG_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SL_W = $clog2(MAX_BLOCKS);
    localparam int PC_W = $clog2(MAX_PAGES + 1);
    localparam int BC_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = 16;
    localparam int PW   = (SL_W + BlockSizeW > OffsetW) ? SL_W + BlockSizeW : OffsetW;
    localparam int AW   = PG_W + SL_W;
    localparam int LW   = SL_W + 1;

    // Allocation state: page count, per-page bump counts and free-list heads.
    t_state              r_state;
    t_state              n_state;
    logic [PC_W-1:0]     r_pages;
    logic [BC_W-1:0]     r_bump     [MAX_PAGES];
    logic [SL_W-1:0]     r_head_slot[MAX_PAGES];
    logic                r_head_vld [MAX_PAGES];
    logic [BlockSizeW-1:0] r_block_size;
    logic [BppW-1:0]     r_bpp;
    logic [PG_W-1:0]     r_pop_page;

    // Link memory: one entry per page and slot, holding the next list element.
    logic [LW-1:0]       mem_link [2**AW];
    logic [LW-1:0]       r_link_rd;

    logic                accept;
    logic                req_ready;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       pages_w;
    logic [CW-1:0]       fp_w;
    logic [CW-1:0]       fs_w;
    logic [PG_W-1:0]     fp_idx;
    logic [SL_W-1:0]     fs_idx;
    logic                bad_free;
    logic                sel_found;
    logic                sel_bump;
    logic [PG_W-1:0]     sel_page;
    logic                room_for_page;
    logic [PG_W-1:0]     new_page;
    logic                do_free;
    logic                do_bump;
    logic                do_pop;
    logic                do_new;
    logic [PG_W-1:0]     res_page;
    logic [SL_W-1:0]     res_slot;
    logic [PW-1:0]       product;
    t_result             res;
    logic                q_full;
    logic                q_valid;
    t_result             q_data;

    assign accept = i_req.valid && req_ready;

    // Blocks per page, held to the range 1 to MAX_BLOCKS.
    always_comb begin
        if (r_bpp == '0) begin
            n_eff = CW'(1);
        end else if (CW'(r_bpp) > CW'(MAX_BLOCKS)) begin
            n_eff = CW'(MAX_BLOCKS);
        end else begin
            n_eff = CW'(r_bpp);
        end
    end

    assign pages_w  = CW'(r_pages);
    assign fp_w     = CW'(i_req.free_page);
    assign fs_w     = CW'(i_req.free_slot);
    assign fp_idx   = fp_w[PG_W-1:0];
    assign fs_idx   = fs_w[SL_W-1:0];
    assign bad_free = (fp_w >= pages_w) || (fs_w >= n_eff);

    // Search the open pages; the newest page with a bump slot or a free
    // list entry wins. Within that page the bump slot comes first.
    always_comb begin
        sel_found = 1'b0;
        sel_bump  = 1'b0;
        sel_page  = '0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            if (CW'(p) < pages_w) begin
                if (CW'(r_bump[p]) < n_eff) begin
                    sel_found = 1'b1;
                    sel_bump  = 1'b1;
                    sel_page  = PG_W'(p);
                end else if (r_head_vld[p]) begin
                    sel_found = 1'b1;
                    sel_bump  = 1'b0;
                    sel_page  = PG_W'(p);
                end
            end
        end
    end

    assign room_for_page = (pages_w < CW'(MAX_PAGES));
    assign new_page      = pages_w[PG_W-1:0];

    assign do_free = accept && (i_req.operation == OP_FREE) && !bad_free;
    assign do_bump = accept && (i_req.operation == OP_ALLOC) && sel_found && sel_bump;
    assign do_pop  = accept && (i_req.operation == OP_ALLOC) && sel_found && !sel_bump;
    assign do_new  = accept && (i_req.operation == OP_ALLOC) && !sel_found && room_for_page;

    // Slot handed out: the bump count, the list head, or slot 0 of a new page.
    always_comb begin
        if (!sel_found) begin
            res_page = new_page;
            res_slot = '0;
        end else if (sel_bump) begin
            res_page = sel_page;
            res_slot = r_bump[sel_page][SL_W-1:0];
        end else begin
            res_page = sel_page;
            res_slot = r_head_slot[sel_page];
        end
    end

    assign product = PW'(res_slot) * PW'(r_block_size);

    always_comb begin
        res.status      = ST_ALLOC;
        res.out_page    = PageFieldW'(CW'(res_page));
        res.out_slot    = SlotFieldW'(CW'(res_slot));
        res.byte_offset = product[OffsetW-1:0];
        if (i_req.operation == OP_FREE) begin
            res.status = bad_free ? ST_BADFREE : ST_FREED;
        end else if (!sel_found && !room_for_page) begin
            res.status = ST_NOPAGE;
        end
        if (res.status != ST_ALLOC) begin
            res.out_page    = '0;
            res.out_slot    = '0;
            res.byte_offset = '0;
        end
    end

    // Sequencer: a pop holds off the next request until the new head is in.
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = do_pop ? S_POP : S_IDLE;
            S_POP:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_IDLE:  req_ready = !q_full;
            S_POP:   req_ready = 1'b0;
            default: req_ready = 1'b0;
        endcase
    end

    assign i_req.ready = req_ready;

    // Link memory: a free writes the old head under the freed handle, a pop
    // reads the link of the head it hands out.
    always_ff @(posedge i_clk) begin
        if (do_free) begin
            mem_link[{fp_idx, fs_idx}] <= {r_head_vld[fp_idx], r_head_slot[fp_idx]};
        end
        if (do_pop) begin
            r_link_rd <= mem_link[{sel_page, r_head_slot[sel_page]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_pop_page <= sel_page;
        end
        if (do_free) begin
            r_head_slot[fp_idx] <= fs_idx;
        end else if (do_new) begin
            r_head_slot[new_page] <= '0;
        end else if (r_state == S_POP) begin
            r_head_slot[r_pop_page] <= r_link_rd[SL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pages      <= PC_W'(1);
            r_block_size <= BlockSizeRst;
            r_bpp        <= BppRst;
            for (int p = 0; p < MAX_PAGES; p++) begin
                r_bump[p]     <= '0;
                r_head_vld[p] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_SIZE:      r_block_size <= i_cfg_wdata[BlockSizeW-1:0];
                    REG_BLOCKS_PER_PAGE: r_bpp        <= i_cfg_wdata[BppW-1:0];
                    default:             r_bpp        <= r_bpp;
                endcase
            end
            if (do_bump) begin
                r_bump[sel_page] <= r_bump[sel_page] + BC_W'(1);
            end
            if (do_new) begin
                r_pages            <= r_pages + PC_W'(1);
                r_bump[new_page]   <= BC_W'(1);
                r_head_vld[new_page] <= 1'b0;
            end
            if (do_free) begin
                r_head_vld[fp_idx] <= 1'b1;
            end else if (r_state == S_POP) begin
                r_head_vld[r_pop_page] <= r_link_rd[SL_W];
            end
        end
    end

    fbpa_result_q u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (o_rsp.ready)
    );

    assign o_rsp.valid       = q_valid;
    assign o_rsp.status      = q_data.status;
    assign o_rsp.out_page    = q_data.out_page;
    assign o_rsp.out_slot    = q_data.out_slot;
    assign o_rsp.byte_offset = q_data.byte_offset;

    // The head update cycle lasts exactly one cycle.
    a_pop_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_IDLE))
        else $error("pop state held longer than one cycle");

    // The head update cycle always follows an accepted request.
    a_pop_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(accept))
        else $error("pop state entered without an accepted request");

    // No request may be taken while a list head is being replaced.
    a_no_accept_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !i_req.ready)
        else $error("request ready during head update");

    // The open page count stays between one and the page limit.
    a_pages_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pages != '0) && (CW'(r_pages) <= CW'(MAX_PAGES)))
        else $error("open page count out of range");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import fbpa_pkg::*;

    // Request word as the driver holds it before it goes on the wire.
    typedef struct packed {
        logic                  op;
        logic [PageFieldW-1:0] page;
        logic [SlotFieldW-1:0] slot;
    } t_req_word;

    // A block handle that the allocator has handed out and not yet been freed by us.
    typedef struct packed {
        logic [PageFieldW-1:0] page;
        logic [SlotFieldW-1:0] slot;
    } t_handle;

    localparam int LongHoldCycles = 300;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgDataW-1:0]  cfg_wdata;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    fixed_block_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the pool. It mirrors the block's page table, bump
    // counts, free-list heads and link memory, and it is advanced once for
    // every request word the block accepts.
    // ------------------------------------------------------------------
    int                    pages_open;
    int                    bump_next [MaxPagesDef];
    logic [SlotFieldW-1:0] head_slot [MaxPagesDef];
    bit                    head_ok   [MaxPagesDef];
    logic [SlotFieldW-1:0] link_slot [MaxPagesDef*MaxBlocksDef];
    bit                    link_ok   [MaxPagesDef*MaxBlocksDef];
    logic [BlockSizeW-1:0] shadow_block_size;
    logic [BppW-1:0]       shadow_bpp;

    // Queues shared by the stimulus, the driver and the monitor.
    t_req_word req_backlog [$];
    t_result   due_results [$];
    t_handle   held_blocks [$];

    int  error_count;
    bit  sender_idle_en;
    bit  recv_idle_en;
    bit  long_hold_go;
    int  alloc_pct;

    task automatic pool_clear();
        pages_open = 1;
        for (int p = 0; p < MaxPagesDef; p++) begin
            bump_next[p] = 0;
            head_slot[p] = '0;
            head_ok[p]   = 1'b0;
        end
        shadow_block_size = BlockSizeRst;
        shadow_bpp        = BppRst;
    endtask

    function automatic t_result grant_word(int pg, logic [SlotFieldW-1:0] s);
        t_result r;
        r             = '0;
        r.status      = ST_ALLOC;
        r.out_page    = PageFieldW'(pg);
        r.out_slot    = s;
        r.byte_offset = OffsetW'(s) * OffsetW'(shadow_block_size);
        return r;
    endfunction

    // Works out the response to one request and updates the shadow pool.
    function automatic t_result pool_step(t_req_word w);
        t_result r;
        int      n;
        int      idx;
        logic [SlotFieldW-1:0] s;
        r = '0;
        // blocks_per_page is saturated into 1..MaxBlocksDef.
        if (shadow_bpp == 0)
            n = 1;
        else if (int'(shadow_bpp) > MaxBlocksDef)
            n = MaxBlocksDef;
        else
            n = int'(shadow_bpp);

        if (w.op == OP_FREE) begin
            // A page that is not open, or a slot beyond the page size, is refused.
            if (int'(w.page) >= pages_open || int'(w.slot) >= n) begin
                r.status = ST_BADFREE;
                return r;
            end
            // Push onto the page's list; double frees are pushed as well.
            idx            = int'(w.page) * MaxBlocksDef + int'(w.slot);
            link_slot[idx] = head_slot[w.page];
            link_ok[idx]   = head_ok[w.page];
            head_slot[w.page] = w.slot;
            head_ok[w.page]   = 1'b1;
            r.status = ST_FREED;
            return r;
        end

        // Newest page first: bump slot if any is left, else pop the free list.
        for (int pg = pages_open - 1; pg >= 0; pg--) begin
            if (bump_next[pg] < n) begin
                s = SlotFieldW'(bump_next[pg]);
                bump_next[pg]++;
                return grant_word(pg, s);
            end
            if (head_ok[pg]) begin
                s   = head_slot[pg];
                idx = pg * MaxBlocksDef + int'(s);
                head_slot[pg] = link_slot[idx];
                head_ok[pg]   = link_ok[idx];
                return grant_word(pg, s);
            end
        end

        if (pages_open >= MaxPagesDef) begin
            r.status = ST_NOPAGE;
            return r;
        end
        // Open a fresh page and hand out its first slot.
        bump_next[pages_open] = 1;
        head_ok[pages_open]   = 1'b0;
        head_slot[pages_open] = '0;
        pages_open++;
        return grant_word(pages_open - 1, '0);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. It offers words from req_backlog, holds a word until
    // it is taken, and inserts random idle bursts when enabled.
    // The shadow pool is advanced at the edge where a word is accepted.
    // ------------------------------------------------------------------
    t_req_word cur_req;
    int        gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_ALLOC;
            req_ch.free_page <= '0;
            req_ch.free_slot <= '0;
            gap_left = 0;
            pool_clear();
        end else begin
            if (req_ch.valid && req_ch.ready)
                due_results.push_back(pool_step(cur_req));
            // A word still waiting for ready stays on the wire untouched.
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= cur_req.op;
                    req_ch.free_page <= cur_req.page;
                    req_ch.free_slot <= cur_req.slot;
                    if (sender_idle_en && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 10);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor. Each accepted response word is checked field by
    // field against the oldest expectation. The ready side stalls in random
    // bursts, and once in the run holds off for a long stretch so that the
    // output queue fills and the block has to refuse requests.
    // ------------------------------------------------------------------
    t_result want;
    int      hold_left;
    int      stall_left;
    logic    rsp_rdy;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left  = 0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("response word with no request pending: status %0d",
                           rsp_ch.status);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.out_page !== want.out_page) begin
                        $error("out_page: expected %0d, got %0d",
                               want.out_page, rsp_ch.out_page);
                        error_count++;
                    end
                    if (rsp_ch.out_slot !== want.out_slot) begin
                        $error("out_slot: expected %0d, got %0d",
                               want.out_slot, rsp_ch.out_slot);
                        error_count++;
                    end
                    if (rsp_ch.byte_offset !== want.byte_offset) begin
                        $error("byte_offset: expected %0d, got %0d",
                               want.byte_offset, rsp_ch.byte_offset);
                        error_count++;
                    end
                    // Granted blocks become candidates for well-formed frees.
                    if (want.status == ST_ALLOC)
                        held_blocks.push_back({want.out_page, want.out_slot});
                end
            end

            if (long_hold_go) begin
                hold_left    = LongHoldCycles;
                long_hold_go = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_rdy = 1'b0;
            end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_rdy    = 1'b0;
            end else begin
                rsp_rdy = 1'b1;
            end
            rsp_ch.ready <= rsp_rdy;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_req(logic op, logic [PageFieldW-1:0] pg, logic [SlotFieldW-1:0] sl);
        req_backlog.push_back({op, pg, sl});
    endtask

    // Registers may only change while nothing is in flight, so every phase
    // boundary waits for the block to drain before it goes on.
    // The check runs on the falling edge, when the driver and the monitor
    // have settled.
    task automatic wait_drained();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || req_ch.valid || due_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BLOCK_SIZE)
            shadow_block_size = val[BlockSizeW-1:0];
        else
            shadow_bpp = val[BppW-1:0];
    endtask

    // Random words, fed a few at a time so that frees can name blocks that
    // were actually granted. Most frees are well formed; the rest are random
    // handles that hit bad pages, bad slots and double frees.
    task automatic feed_random(int count);
        int      r;
        int      k;
        t_handle h;
        for (int i = 0; i < count; i++) begin
            while (req_backlog.size() >= 4)
                @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (r < alloc_pct) begin
                push_req(OP_ALLOC, PageFieldW'($urandom), SlotFieldW'($urandom));
            end else if (r < 90 && held_blocks.size() > 0) begin
                k = $urandom_range(0, held_blocks.size() - 1);
                h = held_blocks[k];
                held_blocks.delete(k);
                push_req(OP_FREE, h.page, h.slot);
            end else begin
                push_req(OP_FREE, PageFieldW'($urandom_range(0, 7)),
                         SlotFieldW'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed words, then random phases, each with
    // its own register settings.
    // ------------------------------------------------------------------
    logic [BlockSizeW-1:0] pick_bs;
    logic [BppW-1:0]       pick_bpp;

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        error_count      = 0;
        sender_idle_en   = 1'b1;
        recv_idle_en     = 1'b1;
        long_hold_go     = 1'b0;
        alloc_pct        = 50;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: 8-byte blocks, full 256-block pages.
        push_req(OP_ALLOC, 3'd0, 8'd0);
        push_req(OP_ALLOC, 3'd7, 8'd255);
        push_req(OP_FREE,  3'd0, 8'd0);
        push_req(OP_FREE,  3'd0, 8'd255);   // block never handed out
        push_req(OP_ALLOC, 3'd0, 8'd0);     // bump slot still preferred
        push_req(OP_FREE,  3'd1, 8'd0);     // page not open
        push_req(OP_FREE,  3'd7, 8'd255);   // page not open
        push_req(OP_FREE,  3'd0, 8'd1);
        push_req(OP_FREE,  3'd0, 8'd1);     // double free
        push_req(OP_ALLOC, 3'd0, 8'd0);
        wait_drained();

        // One-block pages: page 0 is now over its size and lives on its free
        // list alone, so allocations pop that list and no new page opens.
        write_reg(REG_BLOCK_SIZE, 16'hFFFF);
        write_reg(REG_BLOCKS_PER_PAGE, 16'hFE01);
        for (int i = 0; i < 12; i++)
            push_req(OP_ALLOC, 3'd0, 8'd0);
        push_req(OP_FREE,  3'd3, 8'd1);     // slot beyond the page size
        push_req(OP_FREE,  3'd3, 8'd0);
        push_req(OP_ALLOC, 3'd0, 8'd0);
        wait_drained();

        // Zero block size and zero page size, which saturates to one block.
        write_reg(REG_BLOCK_SIZE, 16'd0);
        write_reg(REG_BLOCKS_PER_PAGE, 16'd0);
        push_req(OP_ALLOC, 3'd0, 8'd0);
        push_req(OP_FREE,  3'd5, 8'd0);
        push_req(OP_ALLOC, 3'd0, 8'd0);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    pick_bs  = 16'hFFFF;
                    pick_bpp = 9'd256;
                end
                1: begin
                    pick_bs  = 16'd1;
                    pick_bpp = 9'd2;
                end
                2: begin
                    pick_bs  = BlockSizeW'($urandom);
                    pick_bpp = 9'd511;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: pick_bs = 16'd1;
                        1: pick_bs = 16'hFFFF;
                        default: pick_bs = BlockSizeW'($urandom);
                    endcase
                    case ($urandom_range(0, 5))
                        0: pick_bpp = 9'd1;
                        1: pick_bpp = BppW'($urandom_range(2, 8));
                        2: pick_bpp = 9'd256;
                        3: pick_bpp = BppW'($urandom_range(257, 511));
                        default: pick_bpp = BppW'($urandom_range(1, 256));
                    endcase
                end
            endcase
            write_reg(REG_BLOCK_SIZE, pick_bs);
            write_reg(REG_BLOCKS_PER_PAGE, {7'($urandom), pick_bpp});

            alloc_pct      = $urandom_range(30, 70);
            sender_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en   = ($urandom_range(0, 3) != 0);
            if (ph == 3) begin
                // The receiver stops for a long stretch while requests keep
                // coming, so the output queue fills and ready falls.
                sender_idle_en = 1'b0;
                long_hold_go   = 1'b1;
            end
            if (ph == 9) begin
                sender_idle_en = 1'b0;
                recv_idle_en   = 1'b0;
            end
            feed_random(155);
            wait_drained();
        end

        if (due_results.size() != 0) begin
            $error("%0d response words never arrived", due_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("fixed_block_pool_allocator test passed");
        else
            $display("fixed_block_pool_allocator test failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("fixed_block_pool_allocator test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_req_if.sv
hw/rtl/fbpa_rsp_if.sv
hw/rtl/fbpa_result_q.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/sv/tb.sv
